// ===== src/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lbp_pkg.sv =====
// -----------------------------------------------------------------------------
// LBP package
// Widths, register indexes and payload types for the 3x3 LBP block.
// -----------------------------------------------------------------------------
package lbp_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int PIXEL_BITS     = 8;
  localparam int CODE_BITS      = 8;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = 16;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // One window column, top to bottom.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // One line store word: the two previous rows at one column.
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

endpackage

// ===== src/lbp_pixel_if.sv =====
// -----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one grayscale pixel per transaction.
// -----------------------------------------------------------------------------
interface lbp_pixel_if import lbp_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== src/lbp_result_if.sv =====
// -----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one LBP result per transaction.
// -----------------------------------------------------------------------------
interface lbp_result_if import lbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] lbp_code;
  pixel_t               center_value;
  logic                 window_full;
  logic                 frame_last;

  modport source (output valid, output lbp_code, output center_value,
                  output window_full, output frame_last, input ready);
  modport sink   (input valid, input lbp_code, input center_value,
                  input window_full, input frame_last, output ready);
endinterface

// ===== src/lbp_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lbp_cell.sv =====
// -----------------------------------------------------------------------------
// LBP window cell
// Holds one window column, hands it on at each shift, compares it with the centre.
// -----------------------------------------------------------------------------
module lbp_cell import lbp_pkg::*; (
  input  logic        clk,
  input  logic        shift,
  input  column_t     col_in,
  input  pixel_t      center,
  output column_t     col_out,
  output logic [2:0]  ge        // {bot, mid, top} >= centre
);

  column_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;
  assign ge      = {col.bot >= center, col.mid >= center, col.top >= center};

endmodule

// ===== src/lbp_3x3_pixel_stream.sv =====
// -----------------------------------------------------------------------------
// 3x3 local binary pattern, pixel stream
// Raster pixels in, one LBP result per pixel out, one line store RAM and a
// two-cell window chain.
// -----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and returns exactly one
// result per pixel, in order, through the stage 1 and result registers; one
// pixel per clock is sustained while the output is not stalled, set by the
// single line store RAM (one read and one write per cycle) feeding a two-cell
// column chain. The result describes the window centred one row up and one
// column back from the newest pixel: lbp_code has one bit per neighbour that
// is >= the centre (weights 1,2,4 top row, 8,16 middle row, 32,64,128 bottom
// row), and is 0 unless the whole window lies in the image (window_full).
// center_value carries the raw centre pixel (0 on the first row or column) so
// that border pixels can be passed through. frame_last marks the image's last
// pixel. Writing image_width (index 0, clamped to 3..1024) or image_height
// (index 1, minimum 3) restarts the frame; write only while the block is idle.
// The line store needs no clearing pass after reset: every stored value that
// reaches a result was written earlier in the same frame.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbp_3x3_pixel_stream import lbp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  lbp_pixel_if.sink                 pixels,
  lbp_result_if.source              results
);

  // Frame geometry, held as last column / last row
  logic [COL_BITS-1:0] width_last;
  logic [ROW_BITS-1:0] height_last;
  logic [COL_BITS-1:0] width_last_next;
  logic [ROW_BITS-1:0] height_last_next;
  logic [WIDTH_REG_BITS-1:0]  width_wr;
  logic [HEIGHT_REG_BITS-1:0] height_wr;
  logic                cfg_hit;

  // Raster position of the next pixel
  logic [COL_BITS-1:0] column_count;
  logic [ROW_BITS-1:0] row_count;
  logic                col_at_end;
  logic                row_at_end;

  // Stage 1: pixel waiting on its line store read
  logic                s1_valid;
  pixel_t              s1_pixel;
  logic [COL_BITS-1:0] s1_col;
  logic                s1_full;
  logic                s1_centre;
  logic                s1_last;

  // Handshake
  logic                accept;
  logic                advance;
  logic                fire;

  // Line store and window chain
  line_pair_t          rd_pair;
  line_pair_t          wr_pair;
  column_t             new_col;
  column_t             cell0_col;
  column_t             cell1_col;
  logic [2:0]          ge_new;
  logic [2:0]          ge0;
  logic [2:0]          ge1;
  pixel_t              centre;
  logic [CODE_BITS-1:0] code;

  // Result register
  logic                 out_valid;
  logic [CODE_BITS-1:0] out_code;
  pixel_t               out_centre;
  logic                 out_full;
  logic                 out_last;

  // --- configuration ---------------------------------------------------------
  assign width_wr  = cfg_data[WIDTH_REG_BITS-1:0];
  assign height_wr = cfg_data[HEIGHT_REG_BITS-1:0];
  assign cfg_hit   = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    // clamp width to 3..MAX_WIDTH, height to >= 3
    if (width_wr < WIDTH_REG_BITS'(MIN_DIM)) begin
      width_last_next = COL_BITS'(MIN_DIM - 1);
    end else if (width_wr > WIDTH_REG_BITS'(MAX_WIDTH)) begin
      width_last_next = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      width_last_next = COL_BITS'(width_wr - WIDTH_REG_BITS'(1));
    end
    if (height_wr < HEIGHT_REG_BITS'(MIN_DIM)) begin
      height_last_next = ROW_BITS'(MIN_DIM - 1);
    end else begin
      height_last_next = ROW_BITS'(height_wr - HEIGHT_REG_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= COL_BITS'(MAX_WIDTH - 1);
      height_last <= ROW_BITS'(1024 - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_last  <= width_last_next;
        REG_IMAGE_HEIGHT: height_last <= height_last_next;
        default: ;
      endcase
    end
  end

  // --- handshake --------------------------------------------------------------
  assign advance      = !out_valid || results.ready;
  assign pixels.ready = !s1_valid || advance;
  assign accept       = pixels.valid && pixels.ready;
  assign fire         = s1_valid && advance;

  // --- raster counters --------------------------------------------------------
  assign col_at_end = (column_count == width_last);
  assign row_at_end = (row_count == height_last);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_at_end) begin
        column_count <= '0;
        row_count    <= row_at_end ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

  // --- stage 1: position flags, line store read in flight ---------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixels.pixel;
      s1_col    <= column_count;
      s1_full   <= (row_count >= ROW_BITS'(2)) && (column_count >= COL_BITS'(2));
      s1_centre <= (row_count != '0) && (column_count != '0);
      s1_last   <= col_at_end && row_at_end;
    end
  end

  // Read data holds while stage 1 stalls: a new read only comes with a transaction.
  // Write of column c and next read (column c+1 or 0) never share an address.
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_pixel;

  lbp_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (fire),
    .waddr (s1_col),
    .wdata (wr_pair),
    .re    (accept),
    .raddr (column_count),
    .rdata (rd_pair)
  );

  // --- stage 2: window chain and compare --------------------------------------
  assign new_col.top = rd_pair.upper;
  assign new_col.mid = rd_pair.middle;
  assign new_col.bot = s1_pixel;

  // cell0 holds column-1, cell1 column-2; centre is cell0's middle pixel
  assign centre = cell0_col.mid;

  lbp_cell u_cell0 (
    .clk     (clk),
    .shift   (fire),
    .col_in  (new_col),
    .center  (centre),
    .col_out (cell0_col),
    .ge      (ge0)
  );

  lbp_cell u_cell1 (
    .clk     (clk),
    .shift   (fire),
    .col_in  (cell0_col),
    .center  (centre),
    .col_out (cell1_col),
    .ge      (ge1)
  );

  assign ge_new = {new_col.bot >= centre, new_col.mid >= centre, new_col.top >= centre};

  // weights: top row 1,2,4; middle 8,16; bottom 32,64,128 (left to right)
  assign code = {ge_new[2], ge0[2], ge1[2], ge_new[1], ge1[1], ge_new[0], ge0[0], ge1[0]};

  // --- result register --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code   <= s1_full ? code : '0;
      out_centre <= s1_centre ? centre : '0;
      out_full   <= s1_full;
      out_last   <= s1_last;
    end
  end

  assign results.valid        = out_valid;
  assign results.lbp_code     = out_code;
  assign results.center_value = out_centre;
  assign results.window_full  = out_full;
  assign results.frame_last   = out_last;

  // --- assertions -------------------------------------------------------------
  `LBP_ASSERT_IMP(a_col_in_range, 1'b1, column_count <= width_last, "column count past row end")
  `LBP_ASSERT_IMP(a_border_code_zero, out_valid && !out_full, out_code == '0, "border code not zero")
  `LBP_ASSERT_NXT(a_frame_wrap, accept && col_at_end && row_at_end,
                  column_count == '0 && row_count == '0, "frame end did not wrap counters")
  `LBP_ASSERT_NXT(a_stage_hold, s1_valid && !advance, s1_valid, "stalled pixel dropped")

endmodule
